[src/euler_flux_and_wave_speeds_defines.svh]
// ----------------------------------------------------------------------------
// Euler flux block assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EULER_FLUX_AND_WAVE_SPEEDS_DEFINES_SVH
`define EULER_FLUX_AND_WAVE_SPEEDS_DEFINES_SVH
`ifndef SYNTHESIS
`define EFWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("property failed");
`define EFWS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define EFWS_ASSERT(lbl, prop)
`define EFWS_NEVER(lbl, cond)
`endif
`endif

[src/efws_pkg.sv]
// ----------------------------------------------------------------------------
// Euler flux package
// Types, constants and step functions for the ideal-gas flux pipeline.
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 32;
  localparam int GammaW    = 18;
  localparam int WideW     = 66;
  localparam int DivW      = QW + 1;
  localparam int TW        = GammaW + QW - 1;
  localparam int DivN      = TW + FRAC_BITS;
  localparam int RadW      = 64;
  localparam int SqrtN     = RadW / 2;
  localparam int Latency   = 10 + 2 * DivN + SqrtN;

  localparam logic [GammaW-1:0] GammaReset = GammaW'(91750);
  localparam logic [GammaW:0]   One        = (GammaW + 1)'(1) << FRAC_BITS;
  localparam logic signed [WideW-1:0] ClampQ = WideW'(64'd1 << (QW + 1));

  localparam logic [1:0] DirX = 2'd0;
  localparam logic [1:0] DirY = 2'd1;
  localparam logic [1:0] DirZ = 2'd2;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StBadDensity  = 2'd1,
    StNegPressure = 2'd2,
    StNegEnergy   = 2'd3
  } status_e;

  typedef struct packed {
    logic [QW-1:0]        rho;
    logic [QW-1:0]        nrg;
    logic [2:0][QW-1:0]   mom;
    logic [1:0]           dir;
    logic                 vneg;
    logic [QW-1:0]        vn;
    logic [QW-1:0]        pres;
    status_e              status;
  } item_t;

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [DivN-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [RadW-1:0] x;
    logic [RadW-1:0] r;
  } sqrt_t;

  function automatic logic [QW-1:0] sat32(input logic signed [WideW-1:0] x);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(64'sh7FFF_FFFF);
    lo = -WideW'(64'sh8000_0000);
    if (x > hi) begin
      return 32'h7FFF_FFFF;
    end else if (x < lo) begin
      return 32'h8000_0000;
    end
    return x[QW-1:0];
  endfunction

  // One restoring division step: one quotient bit.
  function automatic div_t div_step(input div_t s, input logic [DivW-1:0] d);
    logic [DivW:0] ext;
    logic [DivW:0] dif;
    logic          ge;
    div_t          o;
    ext = {s.rem, s.quo[DivN-1]};
    dif = ext - {1'b0, d};
    ge  = (ext >= {1'b0, d});
    o.rem = ge ? dif[DivW-1:0] : ext[DivW-1:0];
    o.quo = {s.quo[DivN-2:0], ge};
    return o;
  endfunction

  // One step of the bitwise integer square root.
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [RadW-1:0] b);
    logic [RadW-1:0] sum;
    sqrt_t           o;
    sum = s.r + b;
    if (s.x >= sum) begin
      o.x = s.x - sum;
      o.r = (s.r >> 1) + b;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

endpackage

[src/euler_flux_and_wave_speeds.sv]
// ----------------------------------------------------------------------------
// Euler flux and wave speeds
// Ideal-gas pressure, directional fluxes and outer wave speeds of one cell.
//
//   channel   direction  handshake             payload
//   input     in         start / busy          density .. direction
//   result    out        strobe_o              flux_* pressure speed_* status
//   config    in         cfg_we_i              cfg_wdata_i (gamma)
//
// A beat enters every cycle; busy is never raised. Each result leaves in
// beat order after the 65-step pipelined dividers (two side by side, then
// a third) and the 32-step square root pipeline. Reset clears the valid
// bits and sets gamma to 1.4; the receiver cannot stall, so nothing in the
// pipeline ever waits.
// ----------------------------------------------------------------------------
`include "euler_flux_and_wave_speeds_defines.svh"

module euler_flux_and_wave_speeds
  import efws_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic [GammaW-1:0] cfg_wdata_i,
  input  logic [QW-1:0]     density_i,
  input  logic [QW-1:0]     energy_i,
  input  logic [QW-1:0]     mom_x_i,
  input  logic [QW-1:0]     mom_y_i,
  input  logic [QW-1:0]     mom_z_i,
  input  logic [1:0]        direction_i,
  output logic              strobe_o,
  output logic [QW-1:0]     flux_density_o,
  output logic [QW-1:0]     flux_energy_o,
  output logic [QW-1:0]     flux_mom_x_o,
  output logic [QW-1:0]     flux_mom_y_o,
  output logic [QW-1:0]     flux_mom_z_o,
  output logic [QW-1:0]     pressure_o,
  output logic [QW-1:0]     speed_plus_o,
  output logic [QW-1:0]     speed_minus_o,
  output logic [1:0]        status_o
);

  logic [GammaW-1:0] gamma_q;

  logic              v1_q, v2_q, v4_q, v5_q, v6_q, v9_q, strobe_q;
  logic [DivN:0]     d1v_q;
  logic [DivN:0]     d2v_q;
  logic [SqrtN:0]    qv_q;

  item_t             it1_q, it2_q, it4_q, it5_q, it6_q, it9_q;
  item_t             it1_d, it2_d, it4_d, it6_d;
  logic [2:0][63:0]  sq2_q;
  logic [QW-1:0]     mag2_q;

  item_t             d1it_q [DivN+1];
  div_t              d1k_q  [DivN+1];
  div_t              d1n_q  [DivN+1];
  item_t             d2it_q [DivN+1];
  div_t              d2c_q  [DivN+1];
  item_t             qit_q  [SqrtN+1];
  sqrt_t             qs_q   [SqrtN+1];

  logic signed [QW+2:0]      q4_q;
  logic [FRAC_BITS-1:0]      r4_q;
  logic signed [QW+GammaW+3:0] qg5_q;
  logic signed [FRAC_BITS+GammaW+1:0] rg5_q;

  logic signed [2*QW-1:0]    prho9_q;
  logic signed [2*QW:0]      pe9_q;
  logic signed [2*QW-1:0]    pm9_q [3];
  logic signed [QW+1:0]      spp9_q;
  logic signed [QW+1:0]      spm9_q;

  logic [QW-1:0] fden_q, fnrg_q, pres_q, sp_q, sm_q;
  logic [2:0][QW-1:0] fmom_q;
  logic [1:0]    status_q;

  logic [QW-1:0]              mdir;
  logic signed [WideW-1:0]    vn_w, diff_w, q_w;
  logic [RadW-1:0]            ke_w;
  logic signed [GammaW:0]     g1;
  logic signed [WideW-1:0]    p_w;
  logic [QW-1:0]              p_sat;
  status_e                    st_w;
  logic [TW-1:0]              t_w;
  logic signed [QW:0]         ep_w;
  logic                       ok_w;
  logic signed [WideW-1:0]    fm_w [3];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
    end else if (cfg_we_i) begin
      gamma_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      d1v_q    <= '0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      v6_q     <= 1'b0;
      d2v_q    <= '0;
      qv_q     <= '0;
      v9_q     <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      v1_q     <= start && !busy;
      v2_q     <= v1_q;
      d1v_q    <= {d1v_q[DivN-1:0], v2_q};
      v4_q     <= d1v_q[DivN];
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      d2v_q    <= {d2v_q[DivN-1:0], v6_q};
      qv_q     <= {qv_q[SqrtN-1:0], d2v_q[DivN]};
      v9_q     <= qv_q[SqrtN];
      strobe_q <= v9_q;
    end
  end

  always_comb begin
    case (it1_q.dir)
      DirX:    mdir = it1_q.mom[0];
      DirY:    mdir = it1_q.mom[1];
      DirZ:    mdir = it1_q.mom[2];
      default: mdir = '0;
    endcase
  end

  always_comb begin
    it1_d        = '0;
    it1_d.rho    = density_i;
    it1_d.nrg    = energy_i;
    it1_d.mom[0] = mom_x_i;
    it1_d.mom[1] = mom_y_i;
    it1_d.mom[2] = mom_z_i;
    it1_d.dir    = direction_i;

    it2_d      = it1_q;
    it2_d.vneg = mdir[QW-1];
  end

  // Input capture, squares of the momenta and the velocity numerator.
  always_ff @(posedge clk_i) begin
    it1_q  <= it1_d;
    it2_q  <= it2_d;
    mag2_q <= mdir[QW-1] ? (-mdir) : mdir;
    for (int i = 0; i < 3; i++) begin
      sq2_q[i] <= 64'($signed(it1_q.mom[i]) * $signed(it1_q.mom[i]));
    end
  end

  // Kinetic term and normal velocity dividers, one quotient bit per stage.
  always_ff @(posedge clk_i) begin
    d1it_q[0] <= it2_q;
    d1k_q[0]  <= '{rem: '0, quo: DivN'(sq2_q[0] + sq2_q[1] + sq2_q[2])};
    d1n_q[0]  <= '{rem: '0, quo: DivN'({mag2_q, {FRAC_BITS{1'b0}}})};
    for (int k = 0; k < DivN; k++) begin
      d1it_q[k+1] <= d1it_q[k];
      d1k_q[k+1]  <= div_step(d1k_q[k], {d1it_q[k].rho, 1'b0});
      d1n_q[k+1]  <= div_step(d1n_q[k], {1'b0, d1it_q[k].rho});
    end
  end

  always_comb begin
    ke_w   = d1k_q[DivN].quo[RadW-1:0];
    vn_w   = WideW'(d1n_q[DivN].quo);
    if (d1it_q[DivN].vneg) begin
      vn_w = -vn_w;
    end
    diff_w = WideW'($signed(d1it_q[DivN].nrg)) - $signed({2'b00, ke_w});
    q_w    = diff_w >>> FRAC_BITS;
    if (q_w > ClampQ) begin
      q_w = ClampQ;
    end else if (q_w < -ClampQ) begin
      q_w = -ClampQ;
    end
    it4_d    = d1it_q[DivN];
    it4_d.vn = sat32(vn_w);
  end

  // Internal energy, scaled by gamma minus one, saturated to pressure.
  always_ff @(posedge clk_i) begin
    it4_q    <= it4_d;
    q4_q     <= q_w[QW+2:0];
    r4_q     <= diff_w[FRAC_BITS-1:0];

    it5_q    <= it4_q;
    qg5_q    <= q4_q * g1;
    rg5_q    <= $signed({1'b0, r4_q}) * g1;

    it6_q    <= it6_d;
  end

  always_comb begin
    g1    = $signed({1'b0, gamma_q} - One);
    p_w   = WideW'(qg5_q) + WideW'(rg5_q >>> FRAC_BITS);
    p_sat = sat32(p_w);
    if ($signed(it5_q.rho) <= 0) begin
      st_w = StBadDensity;
    end else if (p_sat[QW-1]) begin
      st_w = StNegPressure;
    end else if (it5_q.nrg[QW-1]) begin
      st_w = StNegEnergy;
    end else begin
      st_w = StOk;
    end
    it6_d        = it5_q;
    it6_d.pres   = ($signed(it5_q.rho) <= 0) ? '0 : p_sat;
    it6_d.status = st_w;
    t_w = gamma_q * it6_q.pres[QW-2:0];
  end

  // Radicand gamma * p / rho, then its integer square root.
  always_ff @(posedge clk_i) begin
    d2it_q[0] <= it6_q;
    d2c_q[0]  <= '{rem: '0, quo: {t_w, {FRAC_BITS{1'b0}}}};
    for (int k = 0; k < DivN; k++) begin
      d2it_q[k+1] <= d2it_q[k];
      d2c_q[k+1]  <= div_step(d2c_q[k], {1'b0, d2it_q[k].rho});
    end

    qit_q[0] <= d2it_q[DivN];
    qs_q[0]  <= '{x: (d2c_q[DivN].quo[DivN-1:RadW] != '0) ? '1
                                                       : d2c_q[DivN].quo[RadW-1:0],
                  r: '0};
    for (int k = 0; k < SqrtN; k++) begin
      qit_q[k+1] <= qit_q[k];
      qs_q[k+1]  <= sqrt_step(qs_q[k], RadW'(64'd1) << (RadW - 2 - 2 * k));
    end
  end

  always_comb begin
    ep_w = (QW+1)'($signed(qit_q[SqrtN].nrg)) + (QW+1)'($signed(qit_q[SqrtN].pres));
  end

  // Flux products and raw wave speeds.
  always_ff @(posedge clk_i) begin
    it9_q   <= qit_q[SqrtN];
    prho9_q <= $signed(qit_q[SqrtN].rho) * $signed(qit_q[SqrtN].vn);
    pe9_q   <= ep_w * $signed(qit_q[SqrtN].vn);
    for (int i = 0; i < 3; i++) begin
      pm9_q[i] <= $signed(qit_q[SqrtN].mom[i]) * $signed(qit_q[SqrtN].vn);
    end
    spp9_q  <= (QW+2)'($signed(qit_q[SqrtN].vn))
             + $signed({2'b00, qs_q[SqrtN].r[QW-1:0]});
    spm9_q  <= (QW+2)'($signed(qit_q[SqrtN].vn))
             - $signed({2'b00, qs_q[SqrtN].r[QW-1:0]});
  end

  always_comb begin
    ok_w = (it9_q.status == StOk) && (it9_q.dir != 2'd3);
    for (int i = 0; i < 3; i++) begin
      fm_w[i] = WideW'(pm9_q[i] >>> FRAC_BITS);
      if (it9_q.dir == 2'(i)) begin
        fm_w[i] = fm_w[i] + WideW'($signed(it9_q.pres));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pres_q   <= it9_q.pres;
    status_q <= it9_q.status;
    if (ok_w) begin
      fden_q <= sat32(WideW'(prho9_q >>> FRAC_BITS));
      fnrg_q <= sat32(WideW'(pe9_q >>> FRAC_BITS));
      for (int i = 0; i < 3; i++) begin
        fmom_q[i] <= sat32(fm_w[i]);
      end
      sp_q <= sat32(WideW'(spp9_q));
      sm_q <= sat32(WideW'(spm9_q));
    end else begin
      fden_q <= '0;
      fnrg_q <= '0;
      fmom_q <= '0;
      sp_q   <= '0;
      sm_q   <= '0;
    end
  end

  assign strobe_o       = strobe_q;
  assign flux_density_o = fden_q;
  assign flux_energy_o  = fnrg_q;
  assign flux_mom_x_o   = fmom_q[0];
  assign flux_mom_y_o   = fmom_q[1];
  assign flux_mom_z_o   = fmom_q[2];
  assign pressure_o     = pres_q;
  assign speed_plus_o   = sp_q;
  assign speed_minus_o  = sm_q;
  assign status_o       = status_q;

  `EFWS_ASSERT(a_result_follows_beat, strobe_o |-> $past(start, Latency))
  `EFWS_ASSERT(a_err_zero, strobe_o && status_o != StOk |-> {fden_q, fnrg_q, sp_q, sm_q} == '0)
  `EFWS_ASSERT(a_speed_order, strobe_o && status_o == StOk |-> $signed(sp_q) >= $signed(sm_q))
  `EFWS_NEVER(a_bad_density_pressure, strobe_o && status_o == StBadDensity && pressure_o != '0)

endmodule

[test/euler_flux_and_wave_speeds_tb.sv]
// ----------------------------------------------------------------------------
// Euler flux and wave speeds testbench
// Drives cells through the flux pipeline under several gamma settings with
// random gaps, predicts every result in a scoreboard and compares it field
// by field in order of arrival.
// ----------------------------------------------------------------------------
module euler_flux_and_wave_speeds_tb
  import efws_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [QW-1:0] f_rho;
    logic [QW-1:0] f_nrg;
    logic [QW-1:0] f_mx;
    logic [QW-1:0] f_my;
    logic [QW-1:0] f_mz;
    logic [QW-1:0] pres;
    logic [QW-1:0] sp;
    logic [QW-1:0] sm;
    status_e       st;
  } flux_t;

  class flux_scoreboard;
    flux_t pending[$];
    int    errors;
    int    checked;
    int    st_seen[4];

    function logic [QW-1:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[QW-1:0];
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function flux_t predict(logic [QW-1:0] d, logic [QW-1:0] e, logic [QW-1:0] mx,
                            logic [QW-1:0] my, logic [QW-1:0] mz, logic [1:0] dir,
                            logic [GammaW-1:0] gam);
      flux_t o;
      longint rho, nrg, diff, q, r, g1, p, vn, c, f;
      longint m[3];
      longint unsigned sq, ke, t, q1, r1, frc, rad;
      rho = longint'($signed(d));
      nrg = longint'($signed(e));
      m[0] = longint'($signed(mx));
      m[1] = longint'($signed(my));
      m[2] = longint'($signed(mz));
      o = '{default: '0, st: StOk};
      if (rho <= 0) begin
        o.st = StBadDensity;
        return o;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += longint'(m[i] * m[i]);
      ke = sq / (2 * longint'(rho));
      diff = nrg - longint'(ke);
      q = diff >>> FRAC_BITS;
      r = diff - (q <<< FRAC_BITS);
      if (q > 64'sd8589934592) q = 64'sd8589934592;
      if (q < -64'sd8589934592) q = -64'sd8589934592;
      g1 = longint'(gam) - 65536;
      p = longint'($signed(clamp32(q * g1 + ((r * g1) >>> FRAC_BITS))));
      o.pres = p[QW-1:0];
      if (p < 0) begin
        o.st = StNegPressure;
      end else if (nrg < 0) begin
        o.st = StNegEnergy;
      end else if (dir != 2'd3) begin
        vn = longint'($signed(clamp32((m[dir] <<< FRAC_BITS) / rho)));
        t = longint'(gam) * p;
        q1 = t / rho;
        r1 = t % rho;
        frc = (r1 << FRAC_BITS) / rho;
        if ((q1 >> (64 - FRAC_BITS)) != 0) rad = 64'hFFFF_FFFF_FFFF_FFFF;
        else rad = (q1 << FRAC_BITS) + frc;
        c = longint'(root64(rad));
        o.f_rho = clamp32((rho * vn) >>> FRAC_BITS);
        o.f_nrg = clamp32(((nrg + p) * vn) >>> FRAC_BITS);
        f = (m[0] * vn) >>> FRAC_BITS;
        o.f_mx = clamp32(dir == DirX ? f + p : f);
        f = (m[1] * vn) >>> FRAC_BITS;
        o.f_my = clamp32(dir == DirY ? f + p : f);
        f = (m[2] * vn) >>> FRAC_BITS;
        o.f_mz = clamp32(dir == DirZ ? f + p : f);
        o.sp = clamp32(vn + c);
        o.sm = clamp32(vn - c);
      end
      return o;
    endfunction

    function void note_cell(logic [QW-1:0] d, logic [QW-1:0] e, logic [QW-1:0] mx,
                            logic [QW-1:0] my, logic [QW-1:0] mz, logic [1:0] dir,
                            logic [GammaW-1:0] gam);
      pending.push_back(predict(d, e, mx, my, mz, dir, gam));
    endfunction

    function void cmp(string name, logic [QW-1:0] exp_v, logic [QW-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(flux_t a);
      flux_t x;
      if (pending.size() == 0) begin
        $error("result beat with no cell outstanding");
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      st_seen[x.st]++;
      cmp("flux_density", x.f_rho, a.f_rho);
      cmp("flux_energy", x.f_nrg, a.f_nrg);
      cmp("flux_mom_x", x.f_mx, a.f_mx);
      cmp("flux_mom_y", x.f_my, a.f_my);
      cmp("flux_mom_z", x.f_mz, a.f_mz);
      cmp("pressure", x.pres, a.pres);
      cmp("speed_plus", x.sp, a.sp);
      cmp("speed_minus", x.sm, a.sm);
      if (x.st !== a.st) begin
        $error("status: expected %0d, got %0d", x.st, a.st);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              cfg_we_i = 1'b0;
  logic [GammaW-1:0] cfg_wdata_i = '0;
  logic [QW-1:0]     density_i = '0;
  logic [QW-1:0]     energy_i = '0;
  logic [QW-1:0]     mom_x_i = '0;
  logic [QW-1:0]     mom_y_i = '0;
  logic [QW-1:0]     mom_z_i = '0;
  logic [1:0]        direction_i = '0;
  logic              strobe_o;
  logic [QW-1:0]     flux_density_o, flux_energy_o, flux_mom_x_o, flux_mom_y_o;
  logic [QW-1:0]     flux_mom_z_o, pressure_o, speed_plus_o, speed_minus_o;
  logic [1:0]        status_o;

  logic [GammaW-1:0] gamma_q = GammaReset;
  flux_scoreboard    sb = new();
  int                idle_cycles = 0;
  int                cells_sent = 0;
  int                gamma_settings = 0;

  localparam int WatchdogLimit = 4000;

  always #5 clk_i = ~clk_i;

  euler_flux_and_wave_speeds uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .density_i(density_i), .energy_i(energy_i), .mom_x_i(mom_x_i),
    .mom_y_i(mom_y_i), .mom_z_i(mom_z_i), .direction_i(direction_i),
    .strobe_o(strobe_o), .flux_density_o(flux_density_o),
    .flux_energy_o(flux_energy_o), .flux_mom_x_o(flux_mom_x_o),
    .flux_mom_y_o(flux_mom_y_o), .flux_mom_z_o(flux_mom_z_o),
    .pressure_o(pressure_o), .speed_plus_o(speed_plus_o),
    .speed_minus_o(speed_minus_o), .status_o(status_o)
  );

  always @(posedge clk_i) begin
    flux_t a;
    if (rst_ni) begin
      if (strobe_o) begin
        a.f_rho = flux_density_o;
        a.f_nrg = flux_energy_o;
        a.f_mx = flux_mom_x_o;
        a.f_my = flux_mom_y_o;
        a.f_mz = flux_mom_z_o;
        a.pres = pressure_o;
        a.sp = speed_plus_o;
        a.sm = speed_minus_o;
        a.st = status_e'(status_o);
        sb.check_result(a);
      end
      if (start && !busy) begin
        sb.note_cell(density_i, energy_i, mom_x_i, mom_y_i, mom_z_i, direction_i, gamma_q);
      end
      if (cfg_we_i) gamma_q <= cfg_wdata_i;
      if ((start && !busy) || strobe_o || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_cell(logic [QW-1:0] d, logic [QW-1:0] e, logic [QW-1:0] mx,
                           logic [QW-1:0] my, logic [QW-1:0] mz, logic [1:0] dir);
    int gap;
    @(negedge clk_i);
    density_i = d;
    energy_i = e;
    mom_x_i = mx;
    mom_y_i = my;
    mom_z_i = mz;
    direction_i = dir;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    cells_sent++;
    if ($urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_pipe();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic set_gamma(logic [GammaW-1:0] g);
    drain_pipe();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = g;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    gamma_settings++;
  endtask

  task automatic send_random_cell();
    logic [QW-1:0] d, e, mx, my, mz;
    logic [1:0]    dir;
    dir = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) begin
      d = $urandom;
      e = $urandom;
      mx = $urandom;
      my = $urandom;
      mz = $urandom;
      dir = 2'($urandom);
    end else begin
      d = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
      if (d == 0) d = 1;
      mx = $signed($urandom) >>> $urandom_range(8, 31);
      my = $signed($urandom) >>> $urandom_range(8, 31);
      mz = $signed($urandom) >>> $urandom_range(8, 31);
      e = $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 24);
    end
    send_cell(d, e, mx, my, mz, dir);
  endtask

  initial begin
    logic [GammaW-1:0] gammas[7];
    int                guard;
    gammas = '{GammaW'(65537), GammaW'(196608), GammaW'(65536), GammaW'(32768),
               GammaW'(262143), GammaW'(109227), GammaW'(91750)};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_cell(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0, 32'h0, DirX);
    send_cell(32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, DirX);
    send_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, DirY);
    send_cell(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, DirZ);
    send_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              DirX);
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              DirY);
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              DirZ);
    send_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, DirZ);
    send_cell(32'h0001_0000, 32'h0000_1000, 32'h0004_0000, 32'h0, 32'h0, DirX);
    send_cell(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, DirX);
    send_cell(32'h0001_0000, 32'h0002_0000, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000,
              2'd3);
    send_cell(32'h0002_0000, 32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000, 32'hFFFF_8000,
              DirY);
    send_cell(32'h0000_0100, 32'h0000_0000, 32'h0, 32'h0, 32'h0, DirX);

    foreach (gammas[k]) begin
      set_gamma(gammas[k]);
      if (gammas[k] <= GammaW'(65536)) begin
        send_cell(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, DirX);
        send_cell(32'h0001_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0, 32'h0, DirY);
      end
      repeat (70) send_random_cell();
    end
    set_gamma(GammaW'($urandom_range(65537, 196608)));
    repeat (20) send_random_cell();

    @(negedge clk_i);
    start = 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < WatchdogLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 20) @(posedge clk_i);
    $display("Sent %0d cells under %0d gamma settings; %0d results checked.",
             cells_sent, gamma_settings, sb.checked);
    $display("Status counts: ok %0d, bad density %0d, neg pressure %0d, neg energy %0d.",
             sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3]);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
